@@ hw/rtl/sbs_pkg.sv @@
// Shared constants for the sorted table binary search unit.
package sbs_pkg;

  localparam int unsigned KEY_W   = 32;  // table key width
  localparam int unsigned INDEX_W = 10;  // entry_index / match_index width
  localparam int unsigned COUNT_W = 11;  // entry_count register width

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

endpackage

@@ hw/rtl/sorted_table_binary_search_unit.sv @@
// Sorted table binary search unit: key table memory, search sequencer, config register.
//
// Channel    | Direction | Signals                                   | Handshake
// -----------+-----------+-------------------------------------------+--------------------------
// command    | in        | operation_i, entry_index_i, key_i         | start & !busy
// result     | out       | found_o, match_index_o                    | done_o strobe, one cycle
// config     | in        | cfg_data_i (entry_count)                  | cfg_valid_i & cfg_ready_o
//
// A write transaction stores one key at the edge that accepts it; busy stays low, so writes
// can follow back to back. A lookup over N entries probes one entry per cycle
// through the table read port with busy high, then the result strobe, during which
// the next command is already taken; an empty table answers without raising busy.
// Reset clears the sequencer and entry_count only; the table is not cleared and
// an entry must be written before a lookup can probe it. The result receiver
// cannot stall, so done_o is never held.
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [sbs_pkg::INDEX_W-1:0]         entry_index_i,
  input  logic signed [sbs_pkg::KEY_W-1:0]    key_i,
  // result
  output logic                                done_o,
  output logic                                found_o,
  output logic [sbs_pkg::INDEX_W-1:0]         match_index_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sbs_pkg::COUNT_W-1:0]         cfg_data_i
);

  // AW addresses the table; CW holds a count or bound up to TABLE_DEPTH.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // sequencer codes
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic                              state_q, state_d;
  logic [CW-1:0]                     count_q;
  logic signed [sbs_pkg::KEY_W-1:0]  key_q;
  logic [CW-1:0]                     lo_q, lo_d;     // inclusive lower bound
  logic [CW-1:0]                     hi_q, hi_d;     // exclusive upper bound
  logic [AW-1:0]                     mid_q, mid_d;   // entry being probed
  logic signed [sbs_pkg::KEY_W-1:0]  rdata_q;

  logic                              done_q, done_d;
  logic                              found_q, found_d;
  logic [sbs_pkg::INDEX_W-1:0]       match_q, match_d;

  logic signed [sbs_pkg::KEY_W-1:0]  key_table [TABLE_DEPTH];

  logic                              accept;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;

  logic [CW:0]                       start_sum;
  logic [CW:0]                       left_sum;
  logic [CW:0]                       right_sum;
  logic [CW-1:0]                     mid_inc;
  logic                              key_lt;
  logic                              key_gt;

  assign accept      = start && !busy;
  assign busy        = (state_q == ST_PROBE);
  assign cfg_ready_o = 1'b1;

  // entry_count, saturated at the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (32'(cfg_data_i) > 32'(TABLE_DEPTH)) begin
        count_q <= CW'(TABLE_DEPTH);
      end else begin
        count_q <= CW'(cfg_data_i);
      end
    end
  end

  // table write port: out-of-range indexes are dropped
  assign wr_en   = accept && (operation_i == sbs_pkg::OP_WRITE) &&
                   (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_table[wr_addr] <= key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= key_table[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_i;
    end
  end

  // Candidate midpoints for both outcomes are formed in parallel with the compare,
  // so the next probe address is only a select after the compare.
  assign start_sum = {1'b0, count_q} - (CW+1)'(1);
  assign left_sum  = {1'b0, lo_q} + (CW+1)'(mid_q) - (CW+1)'(1);
  assign right_sum = (CW+1)'(mid_q) + {1'b0, hi_q};
  assign mid_inc   = CW'(mid_q) + CW'(1);
  assign key_lt    = key_q < rdata_q;
  assign key_gt    = key_q > rdata_q;

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    done_d  = 1'b0;
    found_d = 1'b0;
    match_d = '0;
    rd_en   = 1'b0;
    rd_addr = mid_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == sbs_pkg::OP_LOOKUP)) begin
          lo_d = '0;
          hi_d = count_q;
          if (count_q == '0) begin
            done_d = 1'b1;  // empty table always misses
          end else begin
            mid_d   = AW'(start_sum >> 1);
            rd_en   = 1'b1;
            rd_addr = mid_d;
            state_d = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (key_lt) begin
          hi_d = CW'(mid_q);
          if (lo_q >= CW'(mid_q)) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            mid_d   = AW'(left_sum >> 1);
            rd_en   = 1'b1;
            rd_addr = mid_d;
          end
        end else if (key_gt) begin
          lo_d = mid_inc;
          if (mid_inc >= hi_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            mid_d   = AW'(right_sum >> 1);
            rd_en   = 1'b1;
            rd_addr = mid_d;
          end
        end else begin
          done_d  = 1'b1;
          found_d = 1'b1;
          match_d = sbs_pkg::INDEX_W'(mid_q);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
    match_q <= match_d;
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;

endmodule

@@ hw/rtl/sbs_checker.sv @@
// Port-level checks for the sorted table binary search unit, bound to the top level.
module sbs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              operation_i,
  input logic                              done_o,
  input logic                              found_o,
  input logic [sbs_pkg::INDEX_W-1:0]       match_index_o
);

  // a miss reports index zero
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (match_index_o == '0))
    else $error("miss with nonzero match_index");

  // a write transaction produces no result and does not occupy the unit
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == sbs_pkg::OP_WRITE)) |=> (!done_o && !busy))
    else $error("write transaction raised done or busy");

  // the result cycle is never a busy cycle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a search only ends by delivering its result
  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without a result");

endmodule

bind sorted_table_binary_search_unit sbs_checker u_sbs_checker (.*);

@@ verif/tb.sv @@
// Testbench for the sorted table binary search unit: table loads, lookups and entry_count settings.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned COUNT_MAX   = (1 << sbs_pkg::COUNT_W) - 1;  // widest entry_count value
  localparam int          QUIET_LIMIT = 1000;  // cycles with no transaction before giving up
  localparam logic [sbs_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [sbs_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  // one command transaction as the driver presents it
  typedef struct packed {
    logic                        operation;
    logic [sbs_pkg::INDEX_W-1:0] entry_index;
    logic [sbs_pkg::KEY_W-1:0]   key;
  } command_t;

  // one lookup answer
  typedef struct packed {
    logic                        found;
    logic [sbs_pkg::INDEX_W-1:0] match_index;
  } search_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             start = 1'b0;
  logic                             busy;
  logic                             operation_i = sbs_pkg::OP_WRITE;
  logic [sbs_pkg::INDEX_W-1:0]      entry_index_i = '0;
  logic signed [sbs_pkg::KEY_W-1:0] key_i = '0;
  logic                             done_o;
  logic                             found_o;
  logic [sbs_pkg::INDEX_W-1:0]      match_index_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [sbs_pkg::COUNT_W-1:0]      cfg_data_i = '0;

  sorted_table_binary_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .key_i         (key_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .match_index_o (match_index_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Stimulus side: commands waiting to go out. The head stays in the queue until the
  // block takes it, so "queue empty" really means everything was accepted.
  command_t       pending_commands[$];
  // Lookup answers predicted at acceptance, oldest first.
  search_result_t awaited_results[$];

  // Predictor state: table contents as the block should hold them and the searched span
  // (entry_count after saturation to the table depth).
  logic [sbs_pkg::KEY_W-1:0] stored_keys [TABLE_DEPTH];
  int unsigned               search_span = 0;

  // Generator's view of the table, used to pick keys that hit or sit between entries.
  logic [sbs_pkg::KEY_W-1:0] planned_keys [TABLE_DEPTH];

  int idle_pct  = 0;   // chance per accepted command of an idle burst on start
  int idle_left = 0;

  int n_errors    = 0;
  int n_lookups   = 0;
  int n_hits      = 0;
  int n_writes    = 0;
  int n_cfg       = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Binary search over the predicted table: floor midpoint, narrow left on a smaller
  // key, right on a larger one, stop on equal. Keys compare as signed.
  function automatic search_result_t search_table(input logic [sbs_pkg::KEY_W-1:0] wanted);
    int lo;
    int hi;
    int mid;
    search_result_t res;
    res = '0;
    lo  = 0;
    hi  = int'(search_span) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if ($signed(wanted) < $signed(stored_keys[mid])) begin
        hi = mid - 1;
      end else if ($signed(wanted) > $signed(stored_keys[mid])) begin
        lo = mid + 1;
      end else begin
        res.found       = 1'b1;
        res.match_index = mid[sbs_pkg::INDEX_W-1:0];
        lo              = hi + 1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the head of pending_commands. A command is taken at an edge with
  // start high and busy low; it is then predicted in order, which keeps the predicted
  // table in step with the block. start is held while busy, and after a take an idle
  // burst may start at once, ending inside the command just taken or after it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start         <= 1'b0;
      operation_i   <= sbs_pkg::OP_WRITE;
      entry_index_i <= '0;
      key_i         <= '0;
      idle_left      = 0;
    end else begin
      if (start && !busy) begin : take_command
        command_t taken;
        taken = pending_commands.pop_front();
        if (taken.operation == sbs_pkg::OP_LOOKUP) begin
          awaited_results.push_back(search_table(taken.key));
          n_lookups++;
        end else begin
          stored_keys[taken.entry_index] = taken.key;
          n_writes++;
        end
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) idle_left = $urandom_range(19, 1);
      end
      // while busy the current command must stay put
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_commands.size() != 0) begin
          start         <= 1'b1;
          operation_i   <= pending_commands[0].operation;
          entry_index_i <= pending_commands[0].entry_index;
          key_i         <= pending_commands[0].key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done_o marks one result cycle; compare it with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check_result
      search_result_t want;
      if (awaited_results.size() == 0) begin
        $error("tb: unexpected result found=%0b match_index=%0d", found_o, match_index_o);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        if (found_o !== want.found) begin
          $error("tb: found expected %0b actual %0b", want.found, found_o);
          n_errors++;
        end
        if (match_index_o !== want.match_index) begin
          $error("tb: match_index expected %0d actual %0d", want.match_index, match_index_o);
          n_errors++;
        end
        if (want.found && found_o === 1'b1) n_hits++;
      end
    end
  end

  // Watchdog: any command, result or config transaction clears the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_write(input int unsigned idx,
                                      input logic [sbs_pkg::KEY_W-1:0] k);
    command_t c;
    c.operation   = sbs_pkg::OP_WRITE;
    c.entry_index = idx[sbs_pkg::INDEX_W-1:0];
    c.key         = k;
    pending_commands.push_back(c);
    planned_keys[idx] = k;
  endfunction

  function automatic void queue_lookup(input logic [sbs_pkg::KEY_W-1:0] k);
    command_t c;
    c.operation   = sbs_pkg::OP_LOOKUP;
    // index is don't-care on a lookup; keep it moving anyway
    c.entry_index = sbs_pkg::INDEX_W'($urandom_range(TABLE_DEPTH - 1));
    c.key         = k;
    pending_commands.push_back(c);
  endfunction

  // random slot inside the searched span (0 when the span is empty)
  function automatic int unsigned pick_slot();
    return (search_span > 0) ? $urandom_range(search_span - 1) : 0;
  endfunction

  // Write at idx a key between its neighbors when they are in order, keeping the table ascending.
  function automatic void queue_ordered_write(input int unsigned idx);
    longint lo_k;
    longint hi_k;
    longint pick;
    lo_k = (idx == 0) ? longint'($signed(KEY_MIN)) : longint'($signed(planned_keys[idx - 1]));
    hi_k = (idx == TABLE_DEPTH - 1) ? longint'($signed(KEY_MAX))
                                    : longint'($signed(planned_keys[idx + 1]));
    if (lo_k <= hi_k) begin
      pick = lo_k + (longint'({$urandom, $urandom} >> 1) % (hi_k - lo_k + 1));
      queue_write(idx, pick[sbs_pkg::KEY_W-1:0]);
    end else begin
      queue_write(idx, planned_keys[idx]);  // neighbors already out of order: rewrite as is
    end
  endfunction

  // Key near a table entry, or anywhere: mostly misses, some hits on duplicates or extreme keys.
  function automatic logic [sbs_pkg::KEY_W-1:0] stray_key();
    int unsigned slot;
    slot = pick_slot();
    case ($urandom_range(4))
      0:       return planned_keys[slot] + 1'b1;
      1:       return planned_keys[slot] - 1'b1;
      2:       return KEY_MIN;
      3:       return KEY_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Wait until every command was taken and every answer checked, then let the block settle.
  task automatic drain();
    do @(posedge clk_i); while (pending_commands.size() != 0 || awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // entry_count write, only with the block idle
  task automatic set_entry_count(input int unsigned value);
    drain();
    cfg_data_i  <= value[sbs_pkg::COUNT_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    search_span = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;  // register saturates
    n_cfg++;
  endtask

  // One phase of mixed traffic: ordered table updates and lookups that mostly hit, plus
  // some stray lookups and short out-of-order episodes that get repaired.
  task automatic random_phase(input int n_items);
    int unsigned               slot;
    logic [sbs_pkg::KEY_W-1:0] saved;
    int                        r;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        queue_lookup((search_span > 0) ? planned_keys[pick_slot()] : $urandom);
      end else if (r < 70) begin
        queue_lookup(stray_key());
      end else if (r < 92) begin
        queue_ordered_write(($urandom_range(3) != 0) ? pick_slot()
                                                    : $urandom_range(TABLE_DEPTH - 1));
      end else begin
        // break the ordering at one slot, search a bit, then put the old key back
        slot  = pick_slot();
        saved = planned_keys[slot];
        queue_write(slot, $urandom);
        repeat ($urandom_range(3, 1)) queue_lookup(planned_keys[pick_slot()]);
        queue_write(slot, saved);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int unsigned phase_counts [8];
    int unsigned span_sel;
    longint      acc;

    phase_counts = '{2, 0, 3, 1025, 1024, 7, COUNT_MAX, 1};
    idle_pct     = 30;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: every lookup misses, nothing is probed
    queue_lookup(KEY_MIN);
    queue_lookup(KEY_MAX);
    queue_lookup('0);

    // Load all 1024 entries in ascending order, extremes at both ends and a few
    // duplicate neighbors, so no later lookup can probe an unwritten entry.
    queue_write(0, KEY_MIN);
    acc = longint'($signed(KEY_MIN));
    for (int unsigned i = 1; i < TABLE_DEPTH - 1; i++) begin
      if ($urandom_range(49) != 0) acc += $urandom_range(8_000_000);
      if (acc > longint'($signed(KEY_MAX))) acc = longint'($signed(KEY_MAX));
      queue_write(i, acc[sbs_pkg::KEY_W-1:0]);
    end
    queue_write(TABLE_DEPTH - 1, KEY_MAX);

    // full table: both ends, the first probe, an inner entry and gaps
    set_entry_count(TABLE_DEPTH);
    queue_lookup(KEY_MIN);
    queue_lookup(KEY_MAX);
    queue_lookup(planned_keys[(TABLE_DEPTH - 1) / 2]);
    queue_lookup(planned_keys[300]);
    queue_lookup(planned_keys[300] + 1'b1);
    queue_lookup('0);

    // unsorted: largest key dropped at the first probe position, then repaired
    begin : unsorted_case
      logic [sbs_pkg::KEY_W-1:0] saved;
      saved = planned_keys[(TABLE_DEPTH - 1) / 2];
      queue_write((TABLE_DEPTH - 1) / 2, KEY_MAX);
      queue_lookup(KEY_MAX);
      queue_lookup(planned_keys[800]);
      queue_write((TABLE_DEPTH - 1) / 2, saved);
    end

    // count above the depth saturates to a full table
    set_entry_count(COUNT_MAX);
    queue_lookup(KEY_MAX);
    queue_lookup(planned_keys[TABLE_DEPTH - 2]);

    // one-entry table
    set_entry_count(1);
    queue_lookup(KEY_MIN);
    queue_lookup(planned_keys[1]);
    queue_lookup(KEY_MAX);

    // random phases over a spread of table sizes and idle densities; the last one runs
    // without idling
    for (int p = 0; p < 12; p++) begin
      span_sel = (p < 8) ? phase_counts[p] : $urandom_range(1100, 1);
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      if (p == 11) idle_pct = 0;
      set_entry_count(span_sel);
      random_phase(38);
    end

    drain();
    repeat (16) @(posedge clk_i);

    $display("tb: %0d lookups checked (%0d hits), %0d table writes", n_lookups, n_hits,
             n_writes);
    $display("tb: entry_count written %0d times, from empty through saturated", n_cfg);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sbs_pkg.sv
hw/rtl/sorted_table_binary_search_unit.sv
hw/rtl/sbs_checker.sv
verif/tb.sv
